>>> sv/fms_pkg.sv
package fms_pkg;

    localparam int FFT_POINTS  = 64;
    localparam int LOG2_POINTS = 6;
    localparam int HALF_POINTS = FFT_POINTS / 2;
    localparam int SAMPLE_BITS = 16;
    localparam int DATA_BITS   = 24;
    localparam int TW_BITS     = 18;
    localparam int PROD_BITS   = 48;
    localparam int SQ_BITS     = 44;
    localparam int MAG_BITS    = 22;
    localparam int BIN_BITS    = 6;
    localparam int ADDR_BITS   = LOG2_POINTS;
    localparam int TW_IDX_BITS = LOG2_POINTS - 1;
    localparam int STAGE_BITS  = 3;
    localparam int LAST_STAGE  = LOG2_POINTS - 1;
    localparam int FRAC_BITS   = 16;

    localparam longint unsigned PI_Q40  = 64'h3243F6A8885;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic signed [TW_BITS-1:0] tw_t;
    typedef tw_t tw_tab_t [HALF_POINTS];

    // One complex entry of the working store.
    typedef struct packed {
        logic signed [DATA_BITS-1:0] re;
        logic signed [DATA_BITS-1:0] im;
    } cplx_t;

    // Accumulator operations of the shared multiplier.
    typedef enum logic [2:0] {
        MAC_NONE,
        MAC_LOAD_RE,
        MAC_ADD_RE,
        MAC_LOAD_IM,
        MAC_SUB_IM
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BF_RD,
        S_BF_MUL,
        S_BF_WP,
        S_BF_WQ,
        S_MG_RD,
        S_MG_MUL,
        S_MG_SQRT,
        S_MG_OUT
    } state_t;

    // Cosine or sine of 2 pi a / N in Q30 by a truncated Taylor series.
    // Term k divides by (2k-1)(2k) for the cosine and by (2k)(2k+1) for the sine.
    function automatic longint unsigned trig_q30(input int unsigned a, input bit want_sin);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint sc;
        longint ss;
        x  = (((64'd2 * a * PI_Q40) >> LOG2_POINTS) + 64'd512) >> 10;
        x2 = (x * x) >> 30;
        tc = ONE_Q30;
        ts = x;
        sc = longint'(tc);
        ss = longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd2;    sc = sc - longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd6;    ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd12;   sc = sc + longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd20;   ss = ss + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd30;   sc = sc - longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd42;   ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd56;   sc = sc + longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd72;   ss = ss + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd90;   sc = sc - longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd110;  ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd132;  sc = sc + longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd156;  ss = ss + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd182;  sc = sc - longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd210;  ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd240;  sc = sc + longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd272;  ss = ss + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd306;  sc = sc - longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd342;  ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd380;  sc = sc + longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd420;  ss = ss + longint'(ts);
        if (sc < 0) sc = 0;
        if (ss < 0) ss = 0;
        return want_sin ? longint'(ss) : longint'(sc);
    endfunction

    function automatic longint round_q16(input longint unsigned v);
        return longint'((v + 64'd8192) >> 14);
    endfunction

    function automatic tw_tab_t make_cos_tab();
        tw_tab_t t;
        for (int a = 0; a < HALF_POINTS; a++) begin
            if (4 * a <= FFT_POINTS)
                t[a] = TW_BITS'(round_q16(trig_q30(a, 1'b0)));
            else
                t[a] = TW_BITS'(-round_q16(trig_q30(HALF_POINTS - a, 1'b0)));
        end
        return t;
    endfunction

    function automatic tw_tab_t make_sin_tab();
        tw_tab_t t;
        for (int a = 0; a < HALF_POINTS; a++) begin
            if (4 * a <= FFT_POINTS)
                t[a] = TW_BITS'(round_q16(trig_q30(a, 1'b1)));
            else
                t[a] = TW_BITS'(round_q16(trig_q30(HALF_POINTS - a, 1'b1)));
        end
        return t;
    endfunction

    localparam tw_tab_t TW_COS = make_cos_tab();
    localparam tw_tab_t TW_SIN = make_sin_tab();

    function automatic addr_t bit_rev(input addr_t i);
        addr_t r;
        for (int b = 0; b < ADDR_BITS; b++)
            r[ADDR_BITS-1-b] = i[b];
        return r;
    endfunction

endpackage

>>> sv/fms_mem.sv
module fms_mem (
    input  logic           clk,
    input  logic           we,
    input  fms_pkg::addr_t waddr,
    input  fms_pkg::cplx_t wdata,
    input  fms_pkg::addr_t raddr_a,
    input  fms_pkg::addr_t raddr_b,
    output fms_pkg::cplx_t rdata_a,
    output fms_pkg::cplx_t rdata_b
);
    import fms_pkg::*;

    cplx_t mem [FFT_POINTS];
    cplx_t rdata_a_reg;
    cplx_t rdata_b_reg;

    // Working store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> sv/fms_mac.sv
module fms_mac (
    input  logic                                  clk,
    input  logic signed [fms_pkg::DATA_BITS-1:0]  op_a,
    input  logic signed [fms_pkg::DATA_BITS-1:0]  op_b,
    input  fms_pkg::mac_ctrl_t                    ctrl,
    output logic signed [fms_pkg::PROD_BITS-1:0]  acc_re,
    output logic signed [fms_pkg::PROD_BITS-1:0]  acc_im
);
    import fms_pkg::*;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] acc_re_reg;
    logic signed [PROD_BITS-1:0] acc_im_reg;

    // The product is registered before it reaches the accumulators.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        case (ctrl.op)
            MAC_LOAD_RE: acc_re_reg <= prod_reg;
            MAC_ADD_RE:  acc_re_reg <= acc_re_reg + prod_reg;
            MAC_LOAD_IM: acc_im_reg <= prod_reg;
            MAC_SUB_IM:  acc_im_reg <= acc_im_reg - prod_reg;
            default:     ;
        endcase
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

>>> sv/fms_sqrt.sv
module fms_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fms_pkg::SQ_BITS-1:0]    value,
    output logic                           busy,
    output logic [fms_pkg::MAG_BITS-1:0]   root
);
    import fms_pkg::*;

    localparam int REM_BITS = MAG_BITS + 2;
    localparam int CNT_BITS = $clog2(MAG_BITS);

    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [SQ_BITS-1:0]  rad_reg;
    logic [REM_BITS-1:0] rem_reg;
    logic [MAG_BITS-1:0] root_reg;

    logic [REM_BITS+1:0] shifted;
    logic [REM_BITS+1:0] trial;
    logic                fits;

    // One result bit per cycle, restoring method.
    assign shifted = {rem_reg, rad_reg[SQ_BITS-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign fits    = (shifted >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(MAG_BITS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_BITS-3:0], 2'b00};
            rem_reg  <= fits ? REM_BITS'(shifted - trial) : REM_BITS'(shifted);
            root_reg <= {root_reg[MAG_BITS-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> sv/fft_magnitude_spectrum_unit.sv
// 64-point magnitude spectrum. Real 16-bit samples are taken one request
// at a time while the unit collects a frame; after the 64th sample it stops
// taking samples, runs the six radix-2 stages in place (192 butterflies
// on one shared 24x24 multiplier) and then emits bins 0 to max_bin, each
// through a store read, two squares on the same multiplier and a
// bit-serial square root; a stalled result side holds each bin back.
// The user must write max_bin through the cfg port only between frames;
// the block itself does not enforce this. It resets to 63.
module fft_magnitude_spectrum_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  logic signed [fms_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fms_pkg::BIN_BITS-1:0]           max_bin,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic [fms_pkg::BIN_BITS-1:0]           bin_index,
    output logic [fms_pkg::MAG_BITS-1:0]           magnitude,
    output logic                                   last_bin
);
    import fms_pkg::*;

    state_t                state_reg, state_next;
    logic [2:0]            ph_reg, ph_next;
    logic [STAGE_BITS-1:0] stage_reg, stage_next;
    logic [ADDR_BITS-2:0]  bfly_reg, bfly_next;
    addr_t                 count_reg, count_next;
    logic [BIN_BITS-1:0]   max_bin_reg;

    logic                  result_valid_reg;
    logic [BIN_BITS-1:0]   bin_index_reg;
    logic [MAG_BITS-1:0]   magnitude_reg;
    logic                  last_bin_reg;

    logic signed [DATA_BITS-1:0] ur_reg;
    logic signed [DATA_BITS-1:0] ui_reg;

    logic                  we;
    addr_t                 waddr;
    cplx_t                 wdata;
    addr_t                 raddr_a;
    addr_t                 raddr_b;
    cplx_t                 rdata_a;
    cplx_t                 rdata_b;

    logic signed [DATA_BITS-1:0]  op_a;
    logic signed [DATA_BITS-1:0]  op_b;
    mac_ctrl_t                    mac_ctrl;
    logic signed [PROD_BITS-1:0]  acc_re;
    logic signed [PROD_BITS-1:0]  acc_im;

    logic                  sqrt_start;
    logic                  sqrt_busy;
    logic [MAG_BITS-1:0]   sqrt_root;
    logic                  load_out;

    addr_t                 j_addr;
    addr_t                 p_addr;
    addr_t                 q_addr;
    logic [TW_IDX_BITS-1:0] tw_idx;
    logic signed [DATA_BITS-1:0] wr;
    logic signed [DATA_BITS-1:0] ws;
    logic signed [DATA_BITS-1:0] vr;
    logic signed [DATA_BITS-1:0] vi;

    // Butterfly addressing: p and q from the stage and butterfly counters.
    always_comb
    begin
        j_addr = {1'b0, bfly_reg} & ((addr_t'(1) << stage_reg) - 1'b1);
        p_addr = ((({1'b0, bfly_reg} >> stage_reg) << (stage_reg + 1'b1))) | j_addr;
        q_addr = p_addr | (addr_t'(1) << stage_reg);
        tw_idx = TW_IDX_BITS'(j_addr << (STAGE_BITS'(LAST_STAGE) - stage_reg));
    end

    assign wr = DATA_BITS'(TW_COS[tw_idx]);
    assign ws = DATA_BITS'(TW_SIN[tw_idx]);
    assign vr = acc_re[DATA_BITS+FRAC_BITS-1:FRAC_BITS];
    assign vi = acc_im[DATA_BITS+FRAC_BITS-1:FRAC_BITS];

    fms_mem u_mem (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    fms_mac u_mac (
        .clk    (clk),
        .op_a   (op_a),
        .op_b   (op_b),
        .ctrl   (mac_ctrl),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    fms_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (acc_re[SQ_BITS-1:0]),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    // Sequencer: next state, counters, store and multiplier control.
    always_comb
    begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        stage_next   = stage_reg;
        bfly_next    = bfly_reg;
        count_next   = count_reg;
        sample_ready = 1'b0;
        we           = 1'b0;
        waddr        = p_addr;
        wdata        = '0;
        raddr_a      = p_addr;
        raddr_b      = q_addr;
        op_a         = rdata_b.re;
        op_b         = wr;
        mac_ctrl.op  = MAC_NONE;
        sqrt_start   = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                sample_ready = 1'b1;
                waddr        = bit_rev(count_reg);
                wdata.re     = DATA_BITS'(sample);
                wdata.im     = '0;
                if (sample_valid)
                begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_reg == addr_t'(FFT_POINTS - 1))
                    begin
                        stage_next = '0;
                        bfly_next  = '0;
                        state_next = S_BF_RD;
                    end
                end
            end
            S_BF_RD:
            begin
                ph_next    = '0;
                state_next = S_BF_MUL;
            end
            S_BF_MUL:
            begin
                case (ph_reg)
                    3'd0: begin op_a = rdata_b.re; op_b = wr; end
                    3'd1: begin op_a = rdata_b.im; op_b = ws; end
                    3'd2: begin op_a = rdata_b.im; op_b = wr; end
                    default: begin op_a = rdata_b.re; op_b = ws; end
                endcase
                case (ph_reg)
                    3'd1:    mac_ctrl.op = MAC_LOAD_RE;
                    3'd2:    mac_ctrl.op = MAC_ADD_RE;
                    3'd3:    mac_ctrl.op = MAC_LOAD_IM;
                    3'd4:    mac_ctrl.op = MAC_SUB_IM;
                    default: mac_ctrl.op = MAC_NONE;
                endcase
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd4)
                begin
                    state_next = S_BF_WP;
                end
            end
            S_BF_WP:
            begin
                we         = 1'b1;
                waddr      = p_addr;
                wdata.re   = ur_reg + vr;
                wdata.im   = ui_reg + vi;
                state_next = S_BF_WQ;
            end
            S_BF_WQ:
            begin
                we        = 1'b1;
                waddr     = q_addr;
                wdata.re  = ur_reg - vr;
                wdata.im  = ui_reg - vi;
                bfly_next = bfly_reg + 1'b1;
                if (bfly_reg == '1)
                begin
                    if (stage_reg == STAGE_BITS'(LAST_STAGE))
                    begin
                        count_next = '0;
                        state_next = S_MG_RD;
                    end
                    else
                    begin
                        stage_next = stage_reg + 1'b1;
                        state_next = S_BF_RD;
                    end
                end
                else
                begin
                    state_next = S_BF_RD;
                end
            end
            S_MG_RD:
            begin
                raddr_a    = count_reg;
                ph_next    = '0;
                state_next = S_MG_MUL;
            end
            S_MG_MUL:
            begin
                raddr_a = count_reg;
                if (ph_reg == 3'd0)
                begin
                    op_a = rdata_a.re;
                    op_b = rdata_a.re;
                end
                else
                begin
                    op_a = rdata_a.im;
                    op_b = rdata_a.im;
                end
                case (ph_reg)
                    3'd1:    mac_ctrl.op = MAC_LOAD_RE;
                    3'd2:    mac_ctrl.op = MAC_ADD_RE;
                    default: mac_ctrl.op = MAC_NONE;
                endcase
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd3)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_MG_SQRT;
                end
            end
            S_MG_SQRT:
            begin
                if (!sqrt_busy)
                begin
                    state_next = S_MG_OUT;
                end
            end
            S_MG_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_reg == addr_t'(max_bin_reg))
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_MG_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            ph_reg           <= '0;
            stage_reg        <= '0;
            bfly_reg         <= '0;
            count_reg        <= '0;
            max_bin_reg      <= BIN_BITS'(FFT_POINTS - 1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            stage_reg <= stage_next;
            bfly_reg  <= bfly_next;
            count_reg <= count_next;
            if (cfg_valid)
            begin
                max_bin_reg <= max_bin;
            end
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: butterfly upper input and the output slot.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_BF_MUL && ph_reg == 3'd0)
        begin
            ur_reg <= rdata_a.re;
            ui_reg <= rdata_a.im;
        end
        if (load_out)
        begin
            bin_index_reg <= BIN_BITS'(count_reg);
            magnitude_reg <= sqrt_root;
            last_bin_reg  <= (count_reg == addr_t'(max_bin_reg));
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign bin_index    = bin_index_reg;
    assign magnitude    = magnitude_reg;
    assign last_bin     = last_bin_reg;

`ifndef ASSERT_OFF
    // The root unit is never restarted while it is still working.
    a_sqrt_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("square root started while busy");

    // The final bin of a frame carries the programmed highest bin.
    a_last_bin_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && last_bin) |-> (bin_index == max_bin_reg))
        else $error("last bin does not match max_bin");

    // The stage counter never runs past the final stage.
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BF_RD) |-> (stage_reg <= STAGE_BITS'(LAST_STAGE)))
        else $error("butterfly stage out of range");

    // A new output is only loaded when the slot is free or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!result_valid || result_ready))
        else $error("pending result overwritten");
`endif

endmodule
